// ----- rtl/sltd_pkg.sv -----
// sltd_pkg: shared types and fixed constants of the square-law tone detector
// no dependencies; used by every module of the block
`default_nettype none

package sltd_pkg;

  localparam int REF_W       = 16;
  localparam int SHIFT_W     = 5;
  localparam int SAT_W       = 32;
  localparam int POWER_W     = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd15;

  // fill status of the product queue, seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/sltd_front.sv -----
// sltd_front: accepts input words and forms both reference products
// depends on sltd_pkg; feeds sltd_queue
`default_nettype none

module sltd_front #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int PROD_W       = SAMPLE_WIDTH + sltd_pkg::REF_W,
  parameter int ENTRY_W      = 2 * PROD_W + 1
) (
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic signed [sltd_pkg::REF_W-1:0] ref_cos,
  input  wire logic signed [sltd_pkg::REF_W-1:0] ref_sin,
  input  wire logic                           last,
  input  wire sltd_pkg::q_status_t            q_status,
  output logic                                q_push,
  output logic [ENTRY_W-1:0]                  q_entry
);

  logic signed [PROD_W-1:0] prod_c;
  logic signed [PROD_W-1:0] prod_s;

  assign prod_c = sample * ref_cos;
  assign prod_s = sample * ref_sin;

  // hold off the source only while the queue has no free slot
  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;
  assign q_entry  = {last, prod_c, prod_s};

endmodule

`default_nettype wire

// ----- rtl/sltd_queue.sv -----
// sltd_queue: short fifo of product words between front and back
// depends on sltd_pkg
`default_nettype none

module sltd_queue #(
  parameter int ENTRY_W = 65
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire logic [ENTRY_W-1:0]   push_entry,
  input  wire logic                 pop,
  output logic [ENTRY_W-1:0]        head,
  output sltd_pkg::q_status_t       status
);

  localparam int PTR_W = $clog2(sltd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(sltd_pkg::QUEUE_DEPTH + 1);

  logic [ENTRY_W-1:0] slots [sltd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(sltd_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

// ----- rtl/sltd_back.sv -----
// sltd_back: saturating accumulation, scaling, squaring and power output
// depends on sltd_pkg; drains sltd_queue
`default_nettype none

module sltd_back #(
  parameter int ACC_WIDTH = 48,
  parameter int PROD_W    = 32,
  parameter int ENTRY_W   = 2 * PROD_W + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ENTRY_W-1:0]            head,
  input  wire sltd_pkg::q_status_t           q_status,
  output logic                               q_pop,
  input  wire logic [sltd_pkg::SHIFT_W-1:0]  shift,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sltd_pkg::POWER_W-1:0]       power
);

  localparam int SUM_W = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
  localparam int SAT_W = sltd_pkg::SAT_W;

  function automatic logic signed [ACC_WIDTH-1:0] sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [PROD_W-1:0]    prod
  );
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-ACC_WIDTH:0]  upper;
    logic signed [ACC_WIDTH-1:0] res;
    sum   = {{(SUM_W-ACC_WIDTH){acc[ACC_WIDTH-1]}}, acc}
          + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    upper = sum[SUM_W-1:ACC_WIDTH-1];
    if ((&upper) || !(|upper)) begin
      res = sum[ACC_WIDTH-1:0];
    end else if (sum[SUM_W-1]) begin
      res = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

  function automatic logic [SAT_W-1:0] sat_mag(input logic signed [ACC_WIDTH-1:0] v);
    logic [ACC_WIDTH-SAT_W:0] upper;
    logic [SAT_W-1:0]         s;
    upper = v[ACC_WIDTH-1:SAT_W-1];
    if ((&upper) || !(|upper)) begin
      s = v[SAT_W-1:0];
    end else if (v[ACC_WIDTH-1]) begin
      s = {1'b1, {(SAT_W-1){1'b0}}};
    end else begin
      s = {1'b0, {(SAT_W-1){1'b1}}};
    end
    // magnitude of the most negative value still fits unsigned
    return s[SAT_W-1] ? (~s + SAT_W'(1)) : s;
  endfunction

  logic                        head_last;
  logic signed [PROD_W-1:0]    head_c;
  logic signed [PROD_W-1:0]    head_s;

  logic signed [ACC_WIDTH-1:0] acc_c;
  logic signed [ACC_WIDTH-1:0] acc_s;
  logic signed [ACC_WIDTH-1:0] acc_c_next;
  logic signed [ACC_WIDTH-1:0] acc_s_next;

  logic                        fin_valid;
  logic signed [ACC_WIDTH-1:0] fin_c;
  logic signed [ACC_WIDTH-1:0] fin_s;
  logic                        sc_valid;
  logic [SAT_W-1:0]            mag_c;
  logic [SAT_W-1:0]            mag_s;
  logic                        sq_valid;
  logic [sltd_pkg::POWER_W-1:0] sq_c;
  logic [sltd_pkg::POWER_W-1:0] sq_s;
  logic [sltd_pkg::POWER_W-1:0] sq_c_next;
  logic [sltd_pkg::POWER_W-1:0] sq_s_next;

  logic out_rdy;
  logic sq_rdy;
  logic sc_rdy;
  logic fin_rdy;

  assign head_last = head[ENTRY_W-1];
  assign head_c    = head[2*PROD_W-1:PROD_W];
  assign head_s    = head[PROD_W-1:0];

  assign out_rdy = !out_valid || !out_stall;
  assign sq_rdy  = !sq_valid  || out_rdy;
  assign sc_rdy  = !sc_valid  || sq_rdy;
  assign fin_rdy = !fin_valid || sc_rdy;

  // a closing word waits at the head until the final-sum register has room
  assign q_pop = !q_status.empty && (!head_last || fin_rdy);

  assign acc_c_next = sat_add(acc_c, head_c);
  assign acc_s_next = sat_add(acc_s, head_s);

  assign sq_c_next = mag_c * mag_c;
  assign sq_s_next = mag_s * mag_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_c     <= '0;
      acc_s     <= '0;
      fin_valid <= 1'b0;
      sc_valid  <= 1'b0;
      sq_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        if (head_last) begin
          acc_c <= '0;
          acc_s <= '0;
        end else begin
          acc_c <= acc_c_next;
          acc_s <= acc_s_next;
        end
      end
      if (fin_rdy) begin
        fin_valid <= q_pop && head_last;
      end
      if (sc_rdy) begin
        sc_valid <= fin_valid;
      end
      if (sq_rdy) begin
        sq_valid <= sc_valid;
      end
      if (out_rdy) begin
        out_valid <= sq_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && head_last) begin
      fin_c <= acc_c_next;
      fin_s <= acc_s_next;
    end
    if (sc_rdy && fin_valid) begin
      mag_c <= sat_mag(fin_c >>> shift);
      mag_s <= sat_mag(fin_s >>> shift);
    end
    if (sq_rdy && sc_valid) begin
      sq_c <= sq_c_next;
      sq_s <= sq_s_next;
    end
    if (out_rdy && sq_valid) begin
      power <= sq_c + sq_s;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/square_law_tone_detector_top.sv -----
// result: the last word's sums pass the queue, then the fin, mag, sq and power registers
// throughput: one input word per cycle unless stalled; the back end drains one word
//   per cycle unless a closing word is held; the 4-entry queue absorbs short output stalls
// reset: synchronous, clears accumulators, queue and pipeline; acc_shift returns to 15
// depends on sltd_pkg, sltd_front, sltd_queue, sltd_back
`default_nettype none

module square_law_tone_detector_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write channel: acc_shift
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sltd_pkg::SHIFT_W-1:0]        cfg_data,
  // input word channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      sample,
  input  wire logic signed [sltd_pkg::REF_W-1:0]   ref_cos,
  input  wire logic signed [sltd_pkg::REF_W-1:0]   ref_sin,
  input  wire logic                                last,
  // result word channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [sltd_pkg::POWER_W-1:0]             power
);

  // product width and queue word layout: {last, cos product, sin product}
  localparam int PROD_W  = SAMPLE_WIDTH + sltd_pkg::REF_W;
  localparam int ENTRY_W = 2 * PROD_W + 1;

  logic [sltd_pkg::SHIFT_W-1:0] acc_shift;

  sltd_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;
  logic [ENTRY_W-1:0]  q_entry;
  logic [ENTRY_W-1:0]  q_head;

  // shift register always writable; the user makes writes only while idle, unenforced by the block
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_shift <= sltd_pkg::SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      acc_shift <= cfg_data;
    end
  end

  // front: multiplies each accepted word by both references
  sltd_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PROD_W       (PROD_W),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample   (sample),
    .ref_cos  (ref_cos),
    .ref_sin  (ref_sin),
    .last     (last),
    .q_status (q_status),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  // decoupling queue: lets the front keep taking words while the result waits
  sltd_queue #(
    .ENTRY_W (ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // back: saturating accumulate, then shift/saturate, square and sum on last
  sltd_back #(
    .ACC_WIDTH (ACC_WIDTH),
    .PROD_W    (PROD_W),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .shift     (acc_shift),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .power     (power)
  );

`ifndef SYNTHESIS
  // two squares of magnitudes at most 2^31 each never exceed 2^63
  a_power_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(power[63] && (power[62:0] != 63'd0)))
    else $error("power above 2^63");

  // the back end never drains an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // the front end never overruns the queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push && !q_pop |-> !q_status.full)
    else $error("queue push while full");
`endif

endmodule

`default_nettype wire
